/* design/cansc_pkg.sv */
// ----------------------------------------------------------------------------
// cansc_pkg: shared types, constants and bit-order helpers
// Payload structs, the configuration bundle and the per-item context that
// travels down the divider chain.
// ----------------------------------------------------------------------------
`default_nettype none

package cansc_pkg;

    localparam int PAYLOAD_BYTES = 8;
    localparam int DIV_CELLS     = 65;

    localparam logic [63:0] PAYLOAD_MASK = {64{1'b1}} >> (64 - 8 * PAYLOAD_BYTES);

    localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

    // register indexes
    localparam logic [2:0] REG_START_BIT    = 3'd0;
    localparam logic [2:0] REG_BIT_LENGTH   = 3'd1;
    localparam logic [2:0] REG_BYTE_ORDER   = 3'd2;
    localparam logic [2:0] REG_IS_SIGNED    = 3'd3;
    localparam logic [2:0] REG_SCALE_FACTOR = 3'd4;
    localparam logic [2:0] REG_SCALE_OFFSET = 3'd5;

    localparam logic OP_DECODE = 1'b0;
    localparam logic OP_ENCODE = 1'b1;

    typedef struct packed {
        logic               op;
        logic [63:0]        payload;
        logic signed [63:0] physical_value;
    } in_t;

    typedef struct packed {
        logic [63:0]        payload_out;
        logic signed [63:0] physical_out;
        logic signed [63:0] raw_value;
        logic               overflow;
    } out_t;

    typedef struct packed {
        logic [6:0]  len;     // effective length, 0..64
        logic [5:0]  s0;      // first slot index
        logic        intel;
        logic        sgn;
        logic        fneg;
        logic [31:0] fmag;
        logic [63:0] offset;
    } cfg_t;

    typedef struct packed {
        logic        op;
        logic [63:0] payload;
        logic [63:0] raw;
        logic        neg;
        logic [64:0] quo;     // dividend shifting out, quotient shifting in
        logic [31:0] rem;
    } ctx_t;

    function automatic logic [63:0] rev64(input logic [63:0] x);
        logic [63:0] r;
        for (int k = 0; k < 64; k++)
        begin
            r[k] = x[63 - k];
        end
        return r;
    endfunction

    // Reverse the bits inside each byte (Motorola slot <-> payload bit).
    function automatic logic [63:0] byterev(input logic [63:0] x);
        logic [63:0] r;
        for (int k = 0; k < 64; k++)
        begin
            r[k] = x[(k & ~7) + 7 - (k & 7)];
        end
        return r;
    endfunction

    function automatic logic [63:0] len_mask(input logic [6:0] len);
        logic [63:0] m;
        if (len[6])
        begin
            m = {64{1'b1}};
        end
        else
        begin
            m = (64'd1 << len[5:0]) - 64'd1;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

/* design/cansc_front.sv */
// ----------------------------------------------------------------------------
// cansc_front: field extraction and dividend setup
// Pull the raw field on decode, form |physical - offset| on encode.
// ----------------------------------------------------------------------------
`default_nettype none

module cansc_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            adv,
    input  wire logic            valid_in,
    input  wire cansc_pkg::in_t  req,
    input  wire cansc_pkg::cfg_t cfg,
    output logic                 valid_out,
    output cansc_pkg::ctx_t      ctx_out
);

    logic            valid_reg;
    cansc_pkg::ctx_t ctx_reg;
    cansc_pkg::ctx_t ctx_next;

    logic [63:0] lmask;
    logic [63:0] slots;
    logic [63:0] field;
    logic [63:0] raw;
    logic        sbit;
    logic        rneg;
    logic [64:0] num;
    logic [64:0] nmag;

    always_comb
    begin
        lmask = cansc_pkg::len_mask(cfg.len);
        slots = req.payload & cansc_pkg::PAYLOAD_MASK;
        if (!cfg.intel)
        begin
            slots = cansc_pkg::byterev(slots);
        end
        field = (slots >> cfg.s0) & lmask;
        if (cfg.intel)
        begin
            raw = field;
        end
        else
        begin
            raw = cansc_pkg::rev64(field) >> (7'd64 - cfg.len);
        end
        sbit = (cfg.len != 7'd0) && raw[6'(cfg.len - 7'd1)];
        rneg = cfg.sgn && sbit;
        if (rneg)
        begin
            raw = raw | ~lmask;
        end

        num  = {req.physical_value[63], req.physical_value}
             - {cfg.offset[63], cfg.offset};
        nmag = num[64] ? (~num + 65'd1) : num;

        ctx_next.op      = req.op;
        ctx_next.payload = req.payload;
        ctx_next.rem     = '0;
        if (req.op == cansc_pkg::OP_ENCODE)
        begin
            ctx_next.raw = '0;
            ctx_next.neg = num[64];
            ctx_next.quo = nmag;
        end
        else
        begin
            ctx_next.raw = raw;
            ctx_next.neg = rneg;
            ctx_next.quo = {1'b0, rneg ? (~raw + 64'd1) : raw};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctx_reg <= ctx_next;
        end
    end

    assign valid_out = valid_reg;
    assign ctx_out   = ctx_reg;

endmodule

`default_nettype wire

/* design/cansc_div_cell.sv */
// ----------------------------------------------------------------------------
// cansc_div_cell: one restoring-division step
// Shift one dividend bit into the remainder, subtract the divisor when it
// fits, shift the quotient bit in. Decode items pass through untouched.
// ----------------------------------------------------------------------------
`default_nettype none

module cansc_div_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            adv,
    input  wire logic            valid_in,
    input  wire cansc_pkg::ctx_t ctx_in,
    input  wire logic [31:0]     fmag,
    output logic                 valid_out,
    output cansc_pkg::ctx_t      ctx_out
);

    logic            valid_reg;
    cansc_pkg::ctx_t ctx_reg;
    cansc_pkg::ctx_t ctx_next;
    logic [32:0]     r2;
    logic            ge;

    always_comb
    begin
        r2       = {ctx_in.rem, ctx_in.quo[64]};
        ge       = r2 >= {1'b0, fmag};
        ctx_next = ctx_in;
        if (ctx_in.op == cansc_pkg::OP_ENCODE)
        begin
            ctx_next.quo = {ctx_in.quo[63:0], ge};
            ctx_next.rem = ge ? 32'(r2 - {1'b0, fmag}) : r2[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctx_reg <= ctx_next;
        end
    end

    assign valid_out = valid_reg;
    assign ctx_out   = ctx_reg;

endmodule

`default_nettype wire

/* design/cansc_back.sv */
// ----------------------------------------------------------------------------
// cansc_back: scaling, saturation and bit insertion
// Three stages: partial products or quotient saturation, product merge or
// payload insertion, offset add and saturation into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cansc_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            adv,
    input  wire logic            valid_in,
    input  wire cansc_pkg::ctx_t ctx_in,
    input  wire cansc_pkg::cfg_t cfg,
    output logic                 valid_out,
    output cansc_pkg::out_t      rsp
);

    // stage 1
    logic        v1_reg;
    logic        op1_reg, neg1_reg, ovf1_reg;
    logic [63:0] pay1_reg, raw1_reg;
    logic [63:0] pl1_reg, ph1_reg;
    logic [63:0] raw1_next;
    logic        ovf1_next;
    logic [63:0] qm;

    // stage 2
    logic        v2_reg;
    logic        op2_reg, neg2_reg, ovf2_reg;
    logic [63:0] pay2_reg, raw2_reg;
    logic [95:0] p2_reg;
    logic [63:0] pay2_next;
    logic [63:0] placed;

    // stage 3
    logic            v3_reg;
    cansc_pkg::out_t out_reg;
    cansc_pkg::out_t out_next;
    logic [97:0]     sum;

    always_comb
    begin
        qm        = ctx_in.quo[63:0];
        ovf1_next = 1'b0;
        raw1_next = ctx_in.raw;
        if (ctx_in.op == cansc_pkg::OP_ENCODE)
        begin
            if (cfg.fmag == 32'd0)
            begin
                raw1_next = '0;
                ovf1_next = 1'b1;
            end
            else if (ctx_in.quo[64])
            begin
                raw1_next = (ctx_in.neg ^ cfg.fneg) ? cansc_pkg::SMIN : cansc_pkg::SMAX;
                ovf1_next = 1'b1;
            end
            else if (ctx_in.neg ^ cfg.fneg)
            begin
                if (qm > cansc_pkg::SMIN)
                begin
                    raw1_next = cansc_pkg::SMIN;
                    ovf1_next = 1'b1;
                end
                else
                begin
                    raw1_next = ~qm + 64'd1;
                end
            end
            else if (qm[63])
            begin
                raw1_next = cansc_pkg::SMAX;
                ovf1_next = 1'b1;
            end
            else
            begin
                raw1_next = qm;
            end
        end
    end

    always_comb
    begin
        placed = raw1_reg & cansc_pkg::len_mask(cfg.len);
        if (!cfg.intel)
        begin
            placed = cansc_pkg::rev64(placed) >> (7'd64 - cfg.len);
        end
        placed = placed << cfg.s0;
        if (!cfg.intel)
        begin
            placed = cansc_pkg::byterev(placed);
        end
        pay2_next = pay1_reg;
        if (op1_reg == cansc_pkg::OP_ENCODE)
        begin
            pay2_next = pay1_reg | (placed & cansc_pkg::PAYLOAD_MASK);
        end
    end

    always_comb
    begin
        sum = neg2_reg ? ({{34{cfg.offset[63]}}, cfg.offset} - {2'b00, p2_reg})
                       : ({{34{cfg.offset[63]}}, cfg.offset} + {2'b00, p2_reg});
        out_next.payload_out = pay2_reg;
        out_next.raw_value   = raw2_reg;
        if (op2_reg == cansc_pkg::OP_ENCODE)
        begin
            out_next.physical_out = '0;
            out_next.overflow     = ovf2_reg;
        end
        else if ((sum[97:63] == '0) || (sum[97:63] == '1))
        begin
            out_next.physical_out = sum[63:0];
            out_next.overflow     = 1'b0;
        end
        else
        begin
            out_next.physical_out = sum[97] ? cansc_pkg::SMIN : cansc_pkg::SMAX;
            out_next.overflow     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op1_reg  <= ctx_in.op;
            neg1_reg <= ctx_in.neg ^ cfg.fneg;
            ovf1_reg <= ovf1_next;
            pay1_reg <= ctx_in.payload;
            raw1_reg <= raw1_next;
            pl1_reg  <= 64'(ctx_in.quo[31:0]) * 64'(cfg.fmag);
            ph1_reg  <= 64'(ctx_in.quo[63:32]) * 64'(cfg.fmag);

            op2_reg  <= op1_reg;
            neg2_reg <= neg1_reg;
            ovf2_reg <= ovf1_reg;
            pay2_reg <= pay2_next;
            raw2_reg <= raw1_reg;
            p2_reg   <= {32'd0, pl1_reg} + {ph1_reg, 32'd0};

            out_reg  <= out_next;
        end
    end

    assign valid_out = v3_reg;
    assign rsp       = out_reg;

endmodule

`default_nettype wire

/* design/can_signal_codec.sv */
// ----------------------------------------------------------------------------
// can_signal_codec: CAN signal pack/unpack with fixed-point scaling
// Decodes one signal from, or encodes one signal into, an 8-byte payload.
// ----------------------------------------------------------------------------
// One request enters per cycle; its result passes through one
// extraction stage, a row of 65 restoring-division cells (one quotient bit
// each), and three back-end stages (two 32x32 partial products, merge or
// bit insertion, offset add with saturation into the output register). The
// division chain sets the latency; throughput is one request per clock. When
// the output register holds an untaken result the whole pipeline stalls and
// in_ready drops. Write configuration only while no request is in flight.
`default_nettype none

module can_signal_codec (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire cansc_pkg::in_t  in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output cansc_pkg::out_t      out_data,
    input  wire logic            cfg_we,
    input  wire logic [2:0]      cfg_index,
    input  wire logic [63:0]     cfg_data
);

    logic [5:0]  start_reg;
    logic [6:0]  len_reg;
    logic        order_reg;
    logic        signed_reg;
    logic [31:0] factor_reg;
    logic [63:0] offset_reg;

    cansc_pkg::cfg_t cfg;
    logic            adv;

    logic            cell_v   [cansc_pkg::DIV_CELLS + 1];
    cansc_pkg::ctx_t cell_ctx [cansc_pkg::DIV_CELLS + 1];

    // Register file: the user must write it only while idle; the block itself does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= 6'd0;
            len_reg    <= 7'd8;
            order_reg  <= 1'b1;
            signed_reg <= 1'b0;
            factor_reg <= 32'd65536;
            offset_reg <= 64'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cansc_pkg::REG_START_BIT:    start_reg  <= cfg_data[5:0];
                cansc_pkg::REG_BIT_LENGTH:   len_reg    <= cfg_data[6:0];
                cansc_pkg::REG_BYTE_ORDER:   order_reg  <= cfg_data[0];
                cansc_pkg::REG_IS_SIGNED:    signed_reg <= cfg_data[0];
                cansc_pkg::REG_SCALE_FACTOR: factor_reg <= cfg_data[31:0];
                cansc_pkg::REG_SCALE_OFFSET: offset_reg <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // Derived view: clamp length, map Motorola start bit to its slot,
    // split the factor into sign and magnitude.
    always_comb
    begin
        cfg.len    = (len_reg > 7'd64) ? 7'd64 : len_reg;
        cfg.s0     = order_reg ? start_reg : {start_reg[5:3], ~start_reg[2:0]};
        cfg.intel  = order_reg;
        cfg.sgn    = signed_reg;
        cfg.fneg   = factor_reg[31];
        cfg.fmag   = factor_reg[31] ? (~factor_reg + 32'd1) : factor_reg;
        cfg.offset = offset_reg;
    end

    // Whole pipeline advances unless a finished result is held.
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    cansc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .valid_in  (in_valid),
        .req       (in_data),
        .cfg       (cfg),
        .valid_out (cell_v[0]),
        .ctx_out   (cell_ctx[0])
    );

    // Division chain: each cell retires one quotient bit.
    for (genvar g = 0; g < cansc_pkg::DIV_CELLS; g++)
    begin : g_cell
        cansc_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .valid_in  (cell_v[g]),
            .ctx_in    (cell_ctx[g]),
            .fmag      (cfg.fmag),
            .valid_out (cell_v[g + 1]),
            .ctx_out   (cell_ctx[g + 1])
        );
    end

    cansc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .valid_in  (cell_v[cansc_pkg::DIV_CELLS]),
        .ctx_in    (cell_ctx[cansc_pkg::DIV_CELLS]),
        .cfg       (cfg),
        .valid_out (out_valid),
        .rsp       (out_data)
    );

endmodule

`default_nettype wire

/* design/cansc_checker.sv */
// ----------------------------------------------------------------------------
// cansc_checker: port-level checks for can_signal_codec
// Handshake stability and saturation/flow invariants seen at the ports.
// ----------------------------------------------------------------------------
`default_nettype none

module cansc_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            in_ready,
    input wire logic            out_valid,
    input wire logic            out_ready,
    input wire cansc_pkg::out_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped or changed while stalled");

    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input blocked while output drains");

    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.overflow && out_data.physical_out != 64'sd0 |->
        out_data.physical_out == cansc_pkg::SMAX
        || out_data.physical_out == cansc_pkg::SMIN)
        else $error("overflow without saturated value");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("request taken while pipeline stalled");

endmodule

bind can_signal_codec cansc_checker u_checker (.*);

`default_nettype wire

/* tb/can_signal_codec_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_signal_codec_checker: signal codec scoreboard
// Watches the request and result channels, predicts each result from its own
// copy of the configuration and compares the results in order.
// ----------------------------------------------------------------------------
module can_signal_codec_checker (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic            in_ready,
    input  wire cansc_pkg::in_t  in_data,
    input  wire logic            out_valid,
    input  wire logic            out_ready,
    input  wire cansc_pkg::out_t out_data,
    input  wire logic            cfg_we,
    input  wire logic [2:0]      cfg_index,
    input  wire logic [63:0]     cfg_data,
    output int                   fail_count,
    output int                   pending
);

    logic [5:0]         sig_start;
    logic [6:0]         sig_len;
    logic               sig_intel;
    logic               sig_signed;
    logic signed [31:0] factor_q16;
    logic signed [63:0] offset_q16;

    cansc_pkg::out_t pending_results[$];

    assign pending = pending_results.size();

    // Map signal slot to payload bit; returns -1 when beyond the payload.
    function automatic int slot_bit(input int pos);
        int b;
        b = pos;
        if (!sig_intel)
            b = (pos & ~7) + 7 - (pos & 7);
        if (b >= 8 * cansc_pkg::PAYLOAD_BYTES || b >= 64)
            return -1;
        return b;
    endfunction

    function automatic cansc_pkg::out_t codec_predict(input cansc_pkg::in_t req);
        cansc_pkg::out_t r;
        int len, first, rb, b;
        logic [63:0] raw;
        logic signed [129:0] acc, num, quot;
        logic signed [129:0] lim_hi, lim_lo;
        len = (sig_len > 64) ? 64 : int'(sig_len);
        first = sig_intel ? int'(sig_start)
                          : (int'(sig_start) & ~7) + 7 - (int'(sig_start) & 7);
        lim_hi = 130'sh7FFF_FFFF_FFFF_FFFF;
        lim_lo = -130'sh8000_0000_0000_0000;
        r = '0;
        r.payload_out = req.payload;
        raw = '0;
        if (req.op == cansc_pkg::OP_DECODE)
        begin
            for (int i = 0; i < len; i++)
            begin
                rb = sig_intel ? i : len - 1 - i;
                b = slot_bit(first + i);
                if (b >= 0 && req.payload[b])
                    raw[rb] = 1'b1;
            end
            if (sig_signed && len > 0 && raw[len - 1])
            begin
                if (len < 64)
                    raw = raw | ~((64'd1 << len) - 64'd1);
                acc = $signed({{66{raw[63]}}, raw});
            end
            else
                acc = $signed({66'd0, raw});
            acc = acc * $signed({{98{factor_q16[31]}}, factor_q16})
                + $signed({{66{offset_q16[63]}}, offset_q16});
            if (acc > lim_hi)
            begin
                r.physical_out = cansc_pkg::SMAX;
                r.overflow = 1'b1;
            end
            else if (acc < lim_lo)
            begin
                r.physical_out = cansc_pkg::SMIN;
                r.overflow = 1'b1;
            end
            else r.physical_out = acc[63:0];
            r.raw_value = raw;
        end
        else
        begin
            if (factor_q16 == 0)
            begin
                raw = '0;
                r.overflow = 1'b1;
            end
            else
            begin
                num = $signed({{66{req.physical_value[63]}}, req.physical_value})
                    - $signed({{66{offset_q16[63]}}, offset_q16});
                // SV signed division truncates toward zero
                quot = num / $signed({{98{factor_q16[31]}}, factor_q16});
                if (quot > lim_hi)
                begin
                    raw = cansc_pkg::SMAX;
                    r.overflow = 1'b1;
                end
                else if (quot < lim_lo)
                begin
                    raw = cansc_pkg::SMIN;
                    r.overflow = 1'b1;
                end
                else raw = quot[63:0];
            end
            for (int i = 0; i < len; i++)
            begin
                rb = sig_intel ? i : len - 1 - i;
                b = slot_bit(first + i);
                if (raw[rb] && b >= 0)
                    r.payload_out[b] = 1'b1;
            end
            r.raw_value = raw;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cansc_pkg::out_t exp_r;
        if (!rst_n)
        begin
            sig_start  <= 6'd0;
            sig_len    <= 7'd8;
            sig_intel  <= 1'b1;
            sig_signed <= 1'b0;
            factor_q16 <= 32'sd65536;
            offset_q16 <= 64'sd0;
            fail_count <= 0;
            pending_results.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    cansc_pkg::REG_START_BIT:    sig_start  <= cfg_data[5:0];
                    cansc_pkg::REG_BIT_LENGTH:   sig_len    <= cfg_data[6:0];
                    cansc_pkg::REG_BYTE_ORDER:   sig_intel  <= cfg_data[0];
                    cansc_pkg::REG_IS_SIGNED:    sig_signed <= cfg_data[0];
                    cansc_pkg::REG_SCALE_FACTOR: factor_q16 <= cfg_data[31:0];
                    cansc_pkg::REG_SCALE_OFFSET: offset_q16 <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with no request pending");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (exp_r !== out_data)
                    begin
                        fail_count <= fail_count + 1;
                        if (exp_r.payload_out !== out_data.payload_out)
                            $error("payload_out exp %h got %h",
                                   exp_r.payload_out, out_data.payload_out);
                        if (exp_r.physical_out !== out_data.physical_out)
                            $error("physical_out exp %h got %h",
                                   exp_r.physical_out, out_data.physical_out);
                        if (exp_r.raw_value !== out_data.raw_value)
                            $error("raw_value exp %h got %h",
                                   exp_r.raw_value, out_data.raw_value);
                        if (exp_r.overflow !== out_data.overflow)
                            $error("overflow exp %b got %b",
                                   exp_r.overflow, out_data.overflow);
                    end
                end
            end
            if (in_valid && in_ready)
                pending_results = {pending_results, codec_predict(in_data)};
        end
    end
endmodule

/* tb/tb_can_signal_codec.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_can_signal_codec: signal codec regression
// Drives decode and encode requests through several signal layouts and
// scalings under varying backpressure; the checker does the comparison.
// ----------------------------------------------------------------------------
module tb_can_signal_codec;

    localparam int LATENCY   = 68;
    localparam int WDOG_MAX  = 20000;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    cansc_pkg::in_t    in_data;
    logic              out_valid;
    logic              out_ready;
    cansc_pkg::out_t   out_data;
    logic              cfg_we;
    logic [2:0]        cfg_index;
    logic [63:0]       cfg_data;
    int                fail_count;
    int                pending;

    // idle percentages for sender and receiver, changed per phase
    int send_idle_pct;
    int recv_stall_pct;
    int idle_cycles;

    can_signal_codec uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    can_signal_codec_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver: stall at random per the current phase.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: count cycles with no handshake on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Hold the write enable; setup_signal drops it after the last write.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // Hold valid until the request is taken; gap before it per the phase.
    // Valid stays high after the handshake unless a gap or a drain follows.
    task automatic send_request(input logic op, input logic [63:0] pl,
                                input logic [63:0] phys);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{op: op, payload: pl, physical_value: phys};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Wait until every result is back, then let the pipeline drain.
    task automatic drain;
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        case ($urandom_range(5))
            0: v = 64'd0;
            1: v = {64{1'b1}};
            2: v = cansc_pkg::SMAX;
            3: v = cansc_pkg::SMIN;
            default: ;
        endcase
        return v;
    endfunction

    task automatic setup_signal(input int sb, input int len, input logic intel,
                                input logic sgn, input logic [31:0] fac,
                                input logic [63:0] ofs);
        write_reg(cansc_pkg::REG_START_BIT, 64'(sb));
        write_reg(cansc_pkg::REG_BIT_LENGTH, 64'(len));
        write_reg(cansc_pkg::REG_BYTE_ORDER, {63'd0, intel});
        write_reg(cansc_pkg::REG_IS_SIGNED, {63'd0, sgn});
        write_reg(cansc_pkg::REG_SCALE_FACTOR, {32'd0, fac});
        write_reg(cansc_pkg::REG_SCALE_OFFSET, ofs);
        cfg_we <= 1'b0;
    endtask

    // Random layout with random, often extreme, scaling.
    task automatic random_signal;
        logic [31:0] fac;
        logic [63:0] ofs;
        fac = $urandom();
        case ($urandom_range(6))
            0: fac = 32'h0001_0000;
            1: fac = 32'hFFFF_0000;
            2: fac = 32'h8000_0000;
            3: fac = 32'h7FFF_FFFF;
            4: fac = 32'd0;
            default: ;
        endcase
        ofs = ($urandom_range(2) == 0) ? rand64() : {{32{1'b0}}, $urandom()};
        setup_signal(int'($urandom_range(63)), int'($urandom_range(127)),
                     1'($urandom_range(1)), 1'($urandom_range(1)), fac, ofs);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset layout, then extremes of layout and scaling
        send_request(cansc_pkg::OP_DECODE, 64'h0123_4567_89AB_CDEF, 64'd0);
        send_request(cansc_pkg::OP_ENCODE, 64'd0, 64'h0000_0000_0012_0000);
        drain();
        setup_signal(63, 64, 1'b1, 1'b1, 32'h7FFF_FFFF, cansc_pkg::SMAX);
        send_request(cansc_pkg::OP_DECODE, {64{1'b1}}, 64'd0);
        send_request(cansc_pkg::OP_DECODE, 64'h8000_0000_0000_0000, 64'd0);
        send_request(cansc_pkg::OP_ENCODE, 64'd0, cansc_pkg::SMIN);
        drain();
        setup_signal(7, 64, 1'b0, 1'b0, 32'h8000_0000, cansc_pkg::SMIN);
        send_request(cansc_pkg::OP_DECODE, {64{1'b1}}, 64'd0);
        send_request(cansc_pkg::OP_ENCODE, 64'hAAAA_5555_AAAA_5555, cansc_pkg::SMAX);
        send_request(cansc_pkg::OP_ENCODE, 64'd0, cansc_pkg::SMIN);
        drain();
        // zero length with zero factor
        setup_signal(0, 0, 1'b1, 1'b1, 32'd0, 64'd5);
        send_request(cansc_pkg::OP_DECODE, {64{1'b1}}, 64'd0);
        send_request(cansc_pkg::OP_ENCODE, 64'd0, cansc_pkg::SMAX);
        drain();
        // length above 64, Motorola crossing the payload end
        setup_signal(60, 127, 1'b0, 1'b1, 32'h0000_0001, 64'd0);
        send_request(cansc_pkg::OP_DECODE, 64'hF0F0_0F0F_F0F0_0F0F, 64'd0);
        send_request(cansc_pkg::OP_ENCODE, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(cansc_pkg::OP_ENCODE, 64'd0, cansc_pkg::SMAX);
        drain();
        setup_signal(12, 1, 1'b1, 1'b1, 32'hFFFF_FFFF, 64'd0);
        send_request(cansc_pkg::OP_DECODE, 64'h0000_0000_0000_1000, 64'd0);
        send_request(cansc_pkg::OP_ENCODE, 64'd0, 64'd1);
        drain();

        // random phases: each a new layout and idle pattern
        for (int ph = 0; ph < 20; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            random_signal();
            for (int n = 0; n < 52; n++)
                send_request(1'($urandom_range(1)), rand64(), rand64());
            drain();
        end

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
